FILE: rtl/core/three_zone_motion_profile_assert.svh
// Assertion macros used by the checker file tzmp_checker.
`ifndef THREE_ZONE_MOTION_PROFILE_ASSERT_SVH
`define THREE_ZONE_MOTION_PROFILE_ASSERT_SVH

// Implication check under synchronous reset.
`define TZMP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%s failed", "label");

// Next-cycle implication check under synchronous reset.
`define TZMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%s failed", "label");

`endif

FILE: rtl/core/tzmp_pkg.sv
// ----------------------------------------------------------------------------
// tzmp_pkg
// Shared widths, codes and types of the three-zone motion profile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tzmp_pkg;
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS + 2;
   localparam int LEN_BITS   = DIFF_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + FRAC_BITS;
   localparam int CSR_BITS   = COORD_BITS;
   localparam int CSR_IDX_BITS = 3;
   localparam int REACH_DIV  = 5;

   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_ACCEL    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_RAMP     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOTAL    = 3'd5;

   localparam logic [1:0] CMD_COAST = 2'd0;
   localparam logic [1:0] CMD_HOLD  = 2'd1;
   localparam logic [1:0] CMD_VEL   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT, ST_DECIDE, ST_DIVIDE, ST_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [PROD_BITS-1:0] dividend;
      logic [LEN_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] quotient;
   } div_rsp_type;
endpackage

FILE: rtl/core/tzmp_if.sv
// ----------------------------------------------------------------------------
// tzmp_req_if / tzmp_rsp_if
// Valid/ready channels carrying positions in and commands out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface tzmp_req_if import tzmp_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface tzmp_rsp_if import tzmp_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic                         reached;
   modport source (output valid, command, out_x, out_y, out_z, reached, input ready);
   modport sink   (input valid, command, out_x, out_y, out_z, reached, output ready);
endinterface

FILE: rtl/core/three_zone_motion_profile.sv
// Sequence: after the input transfer the block squares and accumulates the axes, takes the
// root and decides; for a velocity command it then starts the divider per axis, runs its
// steps and takes its done. Hold, coast or a zero-length velocity command skips the divide.
// The block takes one position at a time; a stalled result holds off the next position.
// Reset (synchronous, active high) clears the configuration registers, the reached flag and the sequencer.
// ----------------------------------------------------------------------------
// three_zone_motion_profile
// Bang-coast-bang decision per control tick with serial root and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module three_zone_motion_profile import tzmp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_data,
   tzmp_req_if.sink                req,
   tzmp_rsp_if.source              rsp
);
   localparam int ROOT_STEPS = LEN_BITS;
   localparam int RC_BITS    = $clog2(ROOT_STEPS + 1);

   // configuration registers
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_y_ff, tgt_z_ff;
   logic [FRAC_BITS-1:0]         accel_ff;
   logic [COORD_BITS-2:0]        ramp_ff, total_ff;
   logic                         reached_ff, reached_in;

   state_type state_ff, state_in;

   // item working set
   logic signed [COORD_BITS-1:0] pos_ff [3];
   logic signed [DIFF_BITS-1:0]  diff_ff [3];
   logic [SQ_BITS-1:0]           sum_ff, sum_in;
   logic [1:0]                   axis_ff, axis_in;
   logic [LEN_BITS-1:0]          root_ff, root_in;
   logic [RC_BITS-1:0]           rcnt_ff, rcnt_in;
   logic                         brake_ff, brake_in;
   logic [1:0]                   cmd_ff, cmd_in;
   logic signed [COORD_BITS-1:0] res_ff [3];
   logic                         div_wait_ff, div_wait_in;
   logic                         load;

   // shared multiplier operands: squares in ST_SQUARE, root trial, scaling
   logic [DIFF_BITS-1:0] abs_d;
   logic [LEN_BITS-1:0]  trial_root;
   logic [SQ_BITS-1:0]   trial_sq;
   logic [LEN_BITS-1:0]  mul_a, mul_b;
   logic [SQ_BITS-1:0]   mul_p;
   div_req_type dreq;
   div_rsp_type drsp;
   logic signed [COORD_BITS+1:0] vel;
   logic signed [COORD_BITS-1:0] sat;
   logic [LEN_BITS+2:0] len5;

   tzmp_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign load = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);

   always_comb begin
      abs_d = diff_ff[axis_ff][DIFF_BITS-1] ? DIFF_BITS'(-diff_ff[axis_ff])
                                             : DIFF_BITS'(diff_ff[axis_ff]);
      trial_root = root_ff | (LEN_BITS'(1) << rcnt_ff);
      // one multiplier: trial root squared, axis square, or offset times accel
      mul_a = (state_ff == ST_ROOT) ? trial_root : LEN_BITS'(abs_d);
      if (state_ff == ST_ROOT)
         mul_b = trial_root;
      else if (state_ff == ST_SQUARE)
         mul_b = LEN_BITS'(abs_d);
      else
         mul_b = LEN_BITS'(accel_ff);
      mul_p      = SQ_BITS'(mul_a) * SQ_BITS'(mul_b);
      trial_sq   = mul_p;
      len5       = (LEN_BITS+3)'(root_ff) * (LEN_BITS+3)'(REACH_DIV);
   end

   // next-state logic
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (load) state_in = ST_SQUARE;
         ST_SQUARE: if (axis_ff == 2'd2) state_in = ST_ROOT;
         ST_ROOT:   if (rcnt_ff == '0) state_in = ST_DECIDE;
         ST_DECIDE: state_in = (cmd_in == CMD_VEL && root_ff != '0) ? ST_DIVIDE : ST_OUT;
         ST_DIVIDE: if (drsp.done && axis_ff == 2'd2) state_in = ST_OUT;
         ST_OUT:    if (rsp.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      sum_in      = sum_ff;
      axis_in     = axis_ff;
      root_in     = root_ff;
      rcnt_in     = rcnt_ff;
      brake_in    = brake_ff;
      cmd_in      = cmd_ff;
      reached_in  = reached_ff;
      div_wait_in = div_wait_ff;
      dreq.start    = 1'b0;
      dreq.dividend = PROD_BITS'(mul_p);
      dreq.divisor  = root_ff;
      vel = drsp.quotient > PROD_BITS'((1 << (COORD_BITS - 1)))
            ? (COORD_BITS+2)'(1 << (COORD_BITS - 1))
            : (COORD_BITS+2)'(drsp.quotient);
      if (diff_ff[axis_ff][DIFF_BITS-1] != brake_ff) vel = -vel;
      if (vel > (COORD_BITS+2)'((1 << (COORD_BITS - 1)) - 1))
         sat = COORD_BITS'((1 << (COORD_BITS - 1)) - 1);
      else
         sat = COORD_BITS'(vel);
      unique case (state_ff)
         ST_IDLE: begin
            sum_in  = '0;
            axis_in = 2'd0;
            root_in = '0;
            rcnt_in = RC_BITS'(ROOT_STEPS - 1);
         end
         ST_SQUARE: begin
            // accumulate one axis square per cycle
            sum_in  = sum_ff + mul_p;
            axis_in = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
         end
         ST_ROOT: begin
            // one root bit per cycle, most significant first
            if (trial_sq <= sum_ff) root_in = trial_root;
            if (rcnt_ff != '0) rcnt_in = rcnt_ff - 1'b1;
         end
         ST_DECIDE: begin
            if (len5 < (LEN_BITS+3)'(ramp_ff)) begin
               cmd_in     = CMD_HOLD;
               reached_in = 1'b1;
            end else if (root_ff < LEN_BITS'(ramp_ff)) begin
               cmd_in   = CMD_VEL;
               brake_in = 1'b1;
            end else if ((LEN_BITS+1)'(root_ff) + (LEN_BITS+1)'(ramp_ff)
                         > (LEN_BITS+1)'(total_ff)) begin
               cmd_in   = CMD_VEL;
               brake_in = 1'b0;
            end else begin
               cmd_in = CMD_COAST;
            end
            axis_in     = 2'd0;
            div_wait_in = 1'b0;
         end
         ST_DIVIDE: begin
            if (!div_wait_ff) begin
               dreq.start  = 1'b1;
               div_wait_in = 1'b1;
            end else if (drsp.done) begin
               div_wait_in = 1'b0;
               axis_in     = axis_ff + 2'd1;
            end
         end
         ST_OUT: ;
         default: ;
      endcase
      if (csr_write && (csr_index == REG_TARGET_X || csr_index == REG_TARGET_Y ||
                        csr_index == REG_TARGET_Z))
         reached_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tgt_x_ff    <= '0;
         tgt_y_ff    <= '0;
         tgt_z_ff    <= '0;
         accel_ff    <= '0;
         ramp_ff     <= '0;
         total_ff    <= '0;
         reached_ff  <= 1'b0;
         div_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         reached_ff  <= reached_in;
         div_wait_ff <= div_wait_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_TARGET_X: tgt_x_ff <= csr_data[COORD_BITS-1:0];
               REG_TARGET_Y: tgt_y_ff <= csr_data[COORD_BITS-1:0];
               REG_TARGET_Z: tgt_z_ff <= csr_data[COORD_BITS-1:0];
               REG_ACCEL:    accel_ff <= csr_data[FRAC_BITS-1:0];
               REG_RAMP:     ramp_ff  <= csr_data[COORD_BITS-2:0];
               REG_TOTAL:    total_ff <= csr_data[COORD_BITS-2:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      axis_ff  <= axis_in;
      root_ff  <= root_in;
      rcnt_ff  <= rcnt_in;
      brake_ff <= brake_in;
      cmd_ff   <= cmd_in;
      if (load) begin
         // capture position and offset
         pos_ff[0]  <= req.pos_x;
         pos_ff[1]  <= req.pos_y;
         pos_ff[2]  <= req.pos_z;
         diff_ff[0] <= DIFF_BITS'(tgt_x_ff) - DIFF_BITS'(req.pos_x);
         diff_ff[1] <= DIFF_BITS'(tgt_y_ff) - DIFF_BITS'(req.pos_y);
         diff_ff[2] <= DIFF_BITS'(tgt_z_ff) - DIFF_BITS'(req.pos_z);
      end
      if (state_ff == ST_DECIDE) begin
         if (cmd_in == CMD_HOLD) begin
            res_ff[0] <= pos_ff[0];
            res_ff[1] <= pos_ff[1];
            res_ff[2] <= pos_ff[2];
         end else begin
            res_ff[0] <= '0;
            res_ff[1] <= '0;
            res_ff[2] <= '0;
         end
      end
      if (state_ff == ST_DIVIDE && div_wait_ff && drsp.done)
         res_ff[axis_ff] <= sat;
   end

   assign rsp.command = cmd_ff;
   assign rsp.out_x   = res_ff[0];
   assign rsp.out_y   = res_ff[1];
   assign rsp.out_z   = res_ff[2];
   assign rsp.reached = reached_ff;
endmodule

FILE: rtl/core/tzmp_divider.sv
// ----------------------------------------------------------------------------
// tzmp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tzmp_divider import tzmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int CNT_BITS = $clog2(PROD_BITS + 1);

   logic [PROD_BITS-1:0] quo_ff, quo_in;
   logic [LEN_BITS-1:0]  rem_ff, rem_in;
   logic [LEN_BITS-1:0]  den_ff, den_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [LEN_BITS:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[PROD_BITS-1]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = CNT_BITS'(PROD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = LEN_BITS'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[PROD_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_BITS-1:0];
            quo_in = {quo_ff[PROD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

FILE: rtl/core/tzmp_checker.sv
// ----------------------------------------------------------------------------
// tzmp_checker
// Port-level checks of the motion profile, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_zone_motion_profile_assert.svh"
module tzmp_checker import tzmp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_command,
   input logic       rsp_reached
);
   `TZMP_ASSERT_IMPL(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `TZMP_ASSERT_IMPL(a_hold_sets_reached, clock, reset,
      rsp_valid && rsp_command == CMD_HOLD, rsp_reached)
   `TZMP_ASSERT_IMPL(a_cmd_legal, clock, reset, rsp_valid,
      rsp_command == CMD_COAST || rsp_command == CMD_HOLD || rsp_command == CMD_VEL)
   `TZMP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind three_zone_motion_profile tzmp_checker u_tzmp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_command(rsp.command), .rsp_reached(rsp.reached)
);

FILE: tb/sv/three_zone_motion_profile_checker.sv
// ----------------------------------------------------------------------------
// three_zone_motion_profile_checker
// Watches the position and command channels, predicts each command from its
// own copy of the registers and the reached flag, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module three_zone_motion_profile_checker import tzmp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_data,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [COORD_BITS-1:0]   req_pos_x,
   input  logic [COORD_BITS-1:0]   req_pos_y,
   input  logic [COORD_BITS-1:0]   req_pos_z,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [1:0]              rsp_command,
   input  logic [COORD_BITS-1:0]   rsp_out_x,
   input  logic [COORD_BITS-1:0]   rsp_out_y,
   input  logic [COORD_BITS-1:0]   rsp_out_z,
   input  logic                    rsp_reached,
   output int                      fail_count,
   output int                      pending_count,
   output int                      hold_count,
   output int                      vel_count,
   output int                      coast_count
);
   typedef struct packed {
      logic [1:0]            command;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic                  reached;
   } motion_cmd_type;

   motion_cmd_type          cmd_queue[$];
   logic [COORD_BITS-1:0]   tgt[3];
   logic [FRAC_BITS-1:0]    accel;
   logic [COORD_BITS-2:0]   ramp, total;
   logic                    at_target;

   function automatic logic [COORD_BITS-1:0] velocity_axis(longint d, longint len,
                                                           bit brake);
      longint ad, q, v, hi;
      if (len == 0) return '0;
      ad = d < 0 ? -d : d;
      q = (ad * longint'(accel)) / len;
      v = ((d < 0) != brake) ? -q : q;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[COORD_BITS-1:0];
   endfunction

   // integer square root of a sum below 2^51, bit by bit
   function automatic longint length_of(longint sq);
      longint r, c;
      r = 0;
      for (int b = 30; b >= 0; b--) begin
         c = r | (longint'(1) <<< b);
         if (c * c <= sq) r = c;
      end
      return r;
   endfunction

   task automatic predict_command(input logic [COORD_BITS-1:0] p[3]);
      longint d[3], sq, len;
      motion_cmd_type m;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(tgt[i])) - longint'($signed(p[i]));
         sq += d[i] * d[i];
      end
      len = length_of(sq);
      m = '0;
      if (len * REACH_DIV < longint'(ramp)) begin
         at_target = 1'b1;
         m.command = CMD_HOLD;
         m.x = p[0]; m.y = p[1]; m.z = p[2];
      end else if (len < longint'(ramp) || len + longint'(ramp) > longint'(total)) begin
         m.command = CMD_VEL;
         m.x = velocity_axis(d[0], len, len < longint'(ramp));
         m.y = velocity_axis(d[1], len, len < longint'(ramp));
         m.z = velocity_axis(d[2], len, len < longint'(ramp));
      end else begin
         m.command = CMD_COAST;
      end
      m.reached = at_target;
      cmd_queue.push_back(m);
   endtask

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   assign pending_count = cmd_queue.size();

   always @(posedge clock) begin
      logic [COORD_BITS-1:0] p[3];
      motion_cmd_type m;
      if (reset) begin
         tgt[0] = '0; tgt[1] = '0; tgt[2] = '0;
         accel = '0; ramp = '0; total = '0; at_target = 1'b0;
         cmd_queue.delete();
         fail_count = 0; hold_count = 0; vel_count = 0; coast_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TARGET_X: begin tgt[0] = csr_data; at_target = 1'b0; end
               REG_TARGET_Y: begin tgt[1] = csr_data; at_target = 1'b0; end
               REG_TARGET_Z: begin tgt[2] = csr_data; at_target = 1'b0; end
               REG_ACCEL:    accel = csr_data[FRAC_BITS-1:0];
               REG_RAMP:     ramp = csr_data[COORD_BITS-2:0];
               REG_TOTAL:    total = csr_data[COORD_BITS-2:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (cmd_queue.size() == 0) begin
               $error("command: transfer with no position pending");
               fail_count++;
            end else begin
               m = cmd_queue.pop_front();
               compare_field("command", m.command, rsp_command);
               compare_field("out_x", $signed(m.x), $signed(rsp_out_x));
               compare_field("out_y", $signed(m.y), $signed(rsp_out_y));
               compare_field("out_z", $signed(m.z), $signed(rsp_out_z));
               compare_field("reached", m.reached, rsp_reached);
               case (m.command)
                  CMD_HOLD: hold_count++;
                  CMD_VEL:  vel_count++;
                  default:  coast_count++;
               endcase
            end
         end
         if (req_valid && req_ready) begin
            p[0] = req_pos_x; p[1] = req_pos_y; p[2] = req_pos_z;
            predict_command(p);
         end
      end
   end
endmodule

FILE: tb/sv/three_zone_motion_profile_tb.sv
// ----------------------------------------------------------------------------
// three_zone_motion_profile_tb
// Drives positions and register settings into the block under random idling
// and back-pressure; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module three_zone_motion_profile_tb;
   import tzmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PHASE_ITEMS    = 175;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = REG_TARGET_X;
   logic [CSR_BITS-1:0]     csr_data = '0;
   int                      fail_count, pending_count;
   int                      hold_count, vel_count, coast_count;
   int                      sent_count = 0;
   int                      idle_cycles = 0;
   bit                      long_stall = 1'b0;
   logic [COORD_BITS-1:0]   tgt_now[3];

   tzmp_req_if req ();
   tzmp_rsp_if rsp ();

   three_zone_motion_profile u_top (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req(req.sink), .rsp(rsp.source)
   );

   three_zone_motion_profile_checker u_checker (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_valid(req.valid), .req_ready(req.ready),
      .req_pos_x(req.pos_x), .req_pos_y(req.pos_y), .req_pos_z(req.pos_z),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_command(rsp.command),
      .rsp_out_x(rsp.out_x), .rsp_out_y(rsp.out_y), .rsp_out_z(rsp.out_z),
      .rsp_reached(rsp.reached), .fail_count(fail_count),
      .pending_count(pending_count), .hold_count(hold_count),
      .vel_count(vel_count), .coast_count(coast_count)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
      rsp.ready = 1'b0;
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stall per result; one long hold-off to fill the block.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (long_stall) begin
            rsp.ready <= 1'b0;
            repeat (600) @(posedge clock);
            long_stall = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock iff rsp.valid);
      end
   end

   // Write one register, then leave the port idle before returning.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [CSR_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      if (idx <= REG_TARGET_Z) tgt_now[idx[1:0]] = val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every expected command, then let the block settle.
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Send one position; gap drawn per item, valid held until the transfer.
   task automatic send_pos(input logic [COORD_BITS-1:0] x, y, z, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pos_x <= x; req.pos_y <= y; req.pos_z <= z;
      @(posedge clock iff req.ready);
      sent_count++;
   endtask

   // Position near the target with a random offset of chosen magnitude.
   function automatic logic [COORD_BITS-1:0] near(int axis, int bits);
      logic [COORD_BITS-1:0] off;
      off = COORD_BITS'($urandom());
      off = $signed(off) >>> (COORD_BITS - 1 - bits);
      return tgt_now[axis] + off;
   endfunction

   task automatic set_profile(input logic [CSR_BITS-1:0] a, r, t);
      write_reg(REG_ACCEL, a);
      write_reg(REG_RAMP, r);
      write_reg(REG_TOTAL, t);
   endtask

   initial begin
      int bits;
      logic [CSR_BITS-1:0] r;
      tgt_now[0] = '0; tgt_now[1] = '0; tgt_now[2] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: all registers at reset value, zero-length vector.
      send_pos('0, '0, '0, 1'b1);
      drain();
      // Extreme registers, extreme positions.
      write_reg(REG_TARGET_X, 24'h7FFFFF);
      write_reg(REG_TARGET_Y, 24'h800000);
      write_reg(REG_TARGET_Z, 24'h000001);
      set_profile(24'hFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_pos(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
      send_pos(24'h7FFFFF, 24'h800000, 24'h000001, 1'b0); // zero length, hold
      send_pos(24'h7FFFF0, 24'h800010, 24'h000000, 1'b0);
      drain();
      // Unknown register indexes are ignored.
      write_reg(REG_SPARE_LO, 24'hFFFFFF);
      write_reg(REG_SPARE_HI, 24'h123456);
      // Ramp 0: never hold; total 0 gives accelerate.
      set_profile(24'h8000, 24'h000000, 24'h000000);
      send_pos(24'h000000, 24'h000000, 24'h000000, 1'b0);
      send_pos(24'h7FFFFF, 24'h800000, 24'h000001, 1'b0); // zero length, coast
      drain();
      // Total smaller than ramp, and coast with a large total.
      set_profile(24'h0001, 24'h010000, 24'h000100);
      send_pos(24'h7F0000, 24'h810000, 24'h000000, 1'b0);
      drain();
      set_profile(24'hFFFF, 24'h010000, 24'h7FFFFF);
      send_pos(24'h700000, 24'h900000, 24'h000000, 1'b0); // coast
      send_pos(24'h7FC000, 24'h804000, 24'h000000, 1'b0); // brake
      send_pos(24'h7FFF00, 24'h800100, 24'h000001, 1'b0); // hold
      drain();
      write_reg(REG_TARGET_Z, 24'h000002); // clears reached
      send_pos(24'h000000, 24'h000000, 24'h000000, 1'b0);
      drain();

      // Random phases with fresh targets and profiles.
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_TARGET_X, CSR_BITS'($urandom()));
         write_reg(REG_TARGET_Y, CSR_BITS'($urandom()));
         write_reg(REG_TARGET_Z, CSR_BITS'($urandom()));
         bits = $urandom_range(8, 23);
         r = CSR_BITS'($urandom_range(0, (1 << bits) - 1));
         case (ph)
            0: set_profile(24'hFFFF, 24'h7FFFFF, 24'h7FFFFF);
            1: set_profile(24'h0000, r, 24'h000000);
            default: set_profile(CSR_BITS'($urandom()), r,
                                 CSR_BITS'($urandom_range(0, 24'h7FFFFF)));
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Mix approach positions near the target with far random ones.
            if ($urandom_range(0, 3) == 0)
               send_pos(COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                        COORD_BITS'($urandom()), i % 25 < 8);
            else begin
               bits = $urandom_range(4, 23);
               send_pos(near(0, bits), near(1, bits), near(2, bits), i % 25 < 8);
            end
            if (ph == 3 && i == 10) long_stall = 1'b1;
         end
         drain();
      end

      $display("Covered %0d positions: %0d hold, %0d velocity, %0d coast commands.",
               sent_count, hold_count, vel_count, coast_count);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
